/* rtl/core/grps_pkg.sv */
package grps_pkg;

    typedef struct packed {
        logic        morph_active;
        logic [1:0]  model_source;
        logic [1:0]  model_target;
        logic [15:0] blend_weight;
        logic [7:0]  colour_red;
        logic [7:0]  colour_green;
        logic [7:0]  colour_blue;
        logic [8:0]  brightness;
    } in_item_t;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_last;
    } out_item_t;

    // Classified frame job handed from front to back.
    typedef struct packed {
        logic [1:0]  src;
        logic [1:0]  tgt;
        logic [15:0] weight;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [8:0]  bright;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_POINT,
        ST_TAP,
        ST_EMIT
    } back_state_t;

    localparam int TABLE_COLS = 8;
    localparam int ROM_LAST   = 40;

    function automatic logic [4:0] shape_pos(input logic [1:0] m, input logic [2:0] col);
        logic [4:0] r;
        begin
            r = 5'd0;
            unique case (m)
                2'd0: unique case (col)
                    3'd0, 3'd1: r = 5'd0;
                    3'd2, 3'd3: r = 5'd8;
                    3'd4, 3'd5: r = 5'd16;
                    default:    r = 5'd24;
                endcase
                2'd1: unique case (col)
                    3'd0, 3'd1: r = 5'd0;
                    3'd2: r = 5'd4;
                    3'd3: r = 5'd8;
                    3'd4: r = 5'd16;
                    3'd5: r = 5'd20;
                    3'd6: r = 5'd24;
                    default: r = 5'd28;
                endcase
                2'd2: unique case (col)
                    3'd0, 3'd1: r = 5'd4;
                    3'd2, 3'd3: r = 5'd12;
                    3'd4, 3'd5: r = 5'd20;
                    default:    r = 5'd28;
                endcase
                default: unique case (col)
                    3'd0, 3'd1: r = 5'd0;
                    3'd2, 3'd3: r = 5'd1;
                    3'd4, 3'd5: r = 5'd16;
                    default:    r = 5'd17;
                endcase
            endcase
            return r;
        end
    endfunction

    function automatic logic [8:0] gauss(input logic [5:0] k);
        logic [8:0] g;
        begin
            unique case (k)
                6'd0: g = 9'd256;  6'd1: g = 9'd255;  6'd2: g = 9'd252;
                6'd3: g = 9'd247;  6'd4: g = 9'd240;  6'd5: g = 9'd232;
                6'd6: g = 9'd222;  6'd7: g = 9'd211;  6'd8: g = 9'd199;
                6'd9: g = 9'd187;  6'd10: g = 9'd173; 6'd11: g = 9'd160;
                6'd12: g = 9'd146; 6'd13: g = 9'd132; 6'd14: g = 9'd119;
                6'd15: g = 9'd106; 6'd16: g = 9'd94;  6'd17: g = 9'd83;
                6'd18: g = 9'd72;  6'd19: g = 9'd62;  6'd20: g = 9'd54;
                6'd21: g = 9'd46;  6'd22: g = 9'd39;  6'd23: g = 9'd32;
                6'd24: g = 9'd27;  6'd25: g = 9'd22;  6'd26: g = 9'd18;
                6'd27: g = 9'd15;  6'd28: g = 9'd12;  6'd29: g = 9'd10;
                6'd30: g = 9'd8;   6'd31: g = 9'd6;   6'd32: g = 9'd5;
                6'd33: g = 9'd4;   6'd34: g = 9'd3;   6'd35: g = 9'd2;
                6'd36: g = 9'd2;   6'd37: g = 9'd1;   6'd38: g = 9'd1;
                6'd39: g = 9'd1;
                default: g = 9'd0;
            endcase
            return g;
        end
    endfunction

endpackage

/* rtl/core/grps_front.sv */
module grps_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  grps_pkg::in_item_t in_data,
    output logic              job_valid,
    input  logic              job_stall,
    output grps_pkg::job_t    job_data
);
    // Two-entry queue of classified jobs.
    grps_pkg::job_t q_reg [2];
    logic [1:0] count_reg;
    logic       rd_reg;
    logic       wr_reg;
    grps_pkg::job_t cls;
    logic push, pop;

    always_comb
    begin
        cls.src    = in_data.model_source;
        cls.tgt    = in_data.model_target;
        cls.weight = in_data.morph_active ? in_data.blend_weight : 16'd0;
        cls.red    = in_data.colour_red;
        cls.green  = in_data.colour_green;
        cls.blue   = in_data.colour_blue;
        cls.bright = (in_data.brightness > 9'd256) ? 9'd256 : in_data.brightness;
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign job_valid = (count_reg != 2'd0);
    assign pop       = job_valid && !job_stall;
    assign job_data  = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* rtl/core/grps_back.sv */
module grps_back #(
    parameter int RING_LEDS    = 32,
    parameter int MODEL_POINTS = 8,
    parameter int MODEL_COUNT  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_stall,
    input  grps_pkg::job_t     job_data,
    output logic               out_valid,
    input  logic               out_stall,
    output grps_pkg::out_item_t out_data
);
    localparam int LW = $clog2(RING_LEDS);
    localparam int PW = (MODEL_POINTS > 1) ? $clog2(MODEL_POINTS) : 1;
    localparam logic [LW:0] LAST = (LW+1)'(RING_LEDS - 1);

    grps_pkg::back_state_t state_reg, state_next;
    grps_pkg::job_t job_reg, job_next;
    logic [7:0]  acc_reg [RING_LEDS][3];
    logic [LW:0] led_reg, led_next;
    logic [PW:0] pt_reg, pt_next;
    logic [2:0]  tap_reg, tap_next;
    logic [27:0] pos_reg, pos_next;     // ring position, Q.16 LEDs
    logic        ovalid_reg, ovalid_next;
    grps_pkg::out_item_t odata_reg, odata_next;

    logic [1:0]  ms, mt;
    logic [4:0]  a, b;
    logic [2:0]  col;
    logic [37:0] blend;
    logic [44:0] pscaled;
    logic [11:0] f;
    logic [15:0] frac;
    logic [17:0] absd;
    logic [18:0] kfull;
    logic [5:0]  k;
    logic [8:0]  g;
    logic [LW-1:0] idx;
    logic [12:0] fsum;
    logic [12:0] isum;
    logic [7:0]  cval [3];
    logic [7:0]  addv [3];
    logic [8:0]  sumv [3];
    logic [16:0] prod;
    logic        out_free;

    // model number wraps at MODEL_COUNT; three subtract steps cover a 2-bit number
    always_comb
    begin
        ms = job_reg.src;
        mt = job_reg.tgt;
        for (int r = 0; r < 3; r++)
        begin
            if (int'(ms) >= MODEL_COUNT)
            begin
                ms = ms - 2'(MODEL_COUNT);
            end
            if (int'(mt) >= MODEL_COUNT)
            begin
                mt = mt - 2'(MODEL_COUNT);
            end
        end
    end

    assign col = 3'(pt_reg % grps_pkg::TABLE_COLS);
    assign a   = grps_pkg::shape_pos(ms, col);
    assign b   = grps_pkg::shape_pos(mt, col);
    assign blend = 38'(17'h10000 - {1'b0, job_reg.weight}) * 38'(a)
                 + 38'(job_reg.weight) * 38'(b);
    assign pscaled = (45'(blend) * 45'(RING_LEDS)) >> 5;

    assign f    = pos_reg[27:16];
    assign frac = pos_reg[15:0];
    always_comb
    begin
        unique case (tap_reg)
            3'd0:    absd = {2'b01, frac};
            3'd1:    absd = {2'b00, frac};
            default: absd = {tap_reg[1:0] - 2'd1, 16'd0} - {2'b00, frac};
        endcase
    end
    assign kfull = ({1'b0, absd} + 19'd2048) >> 12;
    assign k     = (kfull > 19'(grps_pkg::ROM_LAST)) ? 6'(grps_pkg::ROM_LAST + 1) : kfull[5:0];
    assign g     = grps_pkg::gauss(k);
    assign fsum  = {1'b0, f} + 13'(RING_LEDS - 1) + {10'd0, tap_reg};

    // fsum stays below three ring lengths, so two compare-subtract steps wrap it
    always_comb
    begin
        isum = fsum;
        if (isum >= 13'(RING_LEDS))
        begin
            isum = isum - 13'(RING_LEDS);
        end
        if (isum >= 13'(RING_LEDS))
        begin
            isum = isum - 13'(RING_LEDS);
        end
    end
    assign idx = isum[LW-1:0];

    assign cval[0] = job_reg.red;
    assign cval[1] = job_reg.green;
    assign cval[2] = job_reg.blue;
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            addv[c] = 8'((17'(cval[c]) * 17'(g) + 17'd128) >> 8);
            sumv[c] = {1'b0, acc_reg[idx][c]} + {1'b0, addv[c]};
        end
    end

    assign out_free  = !ovalid_reg || !out_stall;
    assign job_stall = (state_reg != grps_pkg::ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        led_next    = led_reg;
        pt_next     = pt_reg;
        tap_next    = tap_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg && out_stall;
        odata_next  = odata_reg;
        prod        = 17'd0;
        unique case (state_reg)
            grps_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next   = job_data;
                    state_next = grps_pkg::ST_CLEAR;
                end
            end
            grps_pkg::ST_CLEAR:
            begin
                pt_next    = '0;
                state_next = grps_pkg::ST_POINT;
            end
            grps_pkg::ST_POINT:
            begin
                pos_next   = pscaled[27:0];
                tap_next   = 3'd0;
                state_next = grps_pkg::ST_TAP;
            end
            grps_pkg::ST_TAP:
            begin
                if (tap_reg == 3'd4 || (tap_reg == 3'd3 && frac == 16'd0))
                begin
                    if (pt_reg == (PW+1)'(MODEL_POINTS - 1))
                    begin
                        led_next   = '0;
                        state_next = grps_pkg::ST_EMIT;
                    end
                    else
                    begin
                        pt_next    = pt_reg + 1'b1;
                        state_next = grps_pkg::ST_POINT;
                    end
                end
                else
                begin
                    tap_next = tap_reg + 3'd1;
                end
            end
            grps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next.led_index = 6'(led_reg);
                    prod = 17'(acc_reg[led_reg[LW-1:0]][0]) * 17'(job_reg.bright) + 17'd128;
                    odata_next.out_red = prod[15:8];
                    prod = 17'(acc_reg[led_reg[LW-1:0]][1]) * 17'(job_reg.bright) + 17'd128;
                    odata_next.out_green = prod[15:8];
                    prod = 17'(acc_reg[led_reg[LW-1:0]][2]) * 17'(job_reg.bright) + 17'd128;
                    odata_next.out_blue = prod[15:8];
                    odata_next.frame_last = (led_reg == LAST);
                    led_next = led_reg + 1'b1;
                    if (led_reg == LAST)
                    begin
                        state_next = grps_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = grps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        pos_reg   <= pos_next;
        odata_reg <= odata_next;
        if (state_reg == grps_pkg::ST_TAP)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[idx][c] <= sumv[c][8] ? 8'd255 : sumv[c][7:0];
            end
        end
        else if (state_reg == grps_pkg::ST_CLEAR)
        begin
            for (int i = 0; i < RING_LEDS; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    acc_reg[i][c] <= 8'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= grps_pkg::ST_IDLE;
            led_reg    <= '0;
            pt_reg     <= '0;
            tap_reg    <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            led_reg    <= led_next;
            pt_reg     <= pt_next;
            tap_reg    <= tap_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

/* rtl/core/gaussian_ring_point_splat_unit.sv */
// Gaussian ring splatter: each accepted item is one frame. A front queue (two
// items deep) holds requests; the back sequencer clears the ring, then places
// each point in its own step and splats it onto 4 or 5 LEDs, one LED per step
// through the single accumulator update port, then emits RING_LEDS results,
// one per cycle while the output is not stalled. The back takes no new frame
// until the last result of the current frame has been emitted.
module gaussian_ring_point_splat_unit #(
    parameter int RING_LEDS    = 32,
    parameter int MODEL_POINTS = 8,
    parameter int MODEL_COUNT  = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  grps_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output grps_pkg::out_item_t out_data
);
    logic           job_valid;
    logic           job_stall;
    grps_pkg::job_t job_data;

    grps_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .job_valid(job_valid), .job_stall(job_stall), .job_data(job_data)
    );

    grps_back #(
        .RING_LEDS(RING_LEDS), .MODEL_POINTS(MODEL_POINTS), .MODEL_COUNT(MODEL_COUNT)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_stall(job_stall), .job_data(job_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int LEDS     = 32;
    localparam int POINTS   = 8;
    localparam int N_RANDOM = 250;
    localparam int LIMIT    = 2000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    grps_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    grps_pkg::out_item_t out_data;

    gaussian_ring_point_splat_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    grps_pkg::in_item_t  pending_frames[$];
    grps_pkg::out_item_t expected_leds[$];
    int        fail_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off;
    bit        stim_done;
    bit        in_taken;

    logic [4:0] shape_lut [4][8];
    logic [8:0] gauss_lut [41];

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        shape_lut[0] = '{5'd0, 5'd0, 5'd8, 5'd8, 5'd16, 5'd16, 5'd24, 5'd24};
        shape_lut[1] = '{5'd0, 5'd0, 5'd4, 5'd8, 5'd16, 5'd20, 5'd24, 5'd28};
        shape_lut[2] = '{5'd4, 5'd4, 5'd12, 5'd12, 5'd20, 5'd20, 5'd28, 5'd28};
        shape_lut[3] = '{5'd0, 5'd0, 5'd1, 5'd1, 5'd16, 5'd16, 5'd17, 5'd17};
        gauss_lut = '{256, 255, 252, 247, 240, 232, 222, 211, 199, 187,
                      173, 160, 146, 132, 119, 106, 94, 83, 72, 62,
                      54, 46, 39, 32, 27, 22, 18, 15, 12, 10,
                      8, 6, 5, 4, 3, 2, 2, 1, 1, 1, 0};
    end

    // Builds the ring for one frame and queues the 32 LED results.
    task automatic predict_frame(input grps_pkg::in_item_t req);
        logic [7:0]  ring [LEDS][3];
        logic [7:0]  colour [3];
        logic [63:0] w, blend, pos, frac, absd, k, sum;
        logic [8:0]  g, bright;
        int          f, taps, idx;
        grps_pkg::out_item_t led;
        w = req.morph_active ? 64'(req.blend_weight) : 64'd0;
        bright = (req.brightness > 9'd256) ? 9'd256 : req.brightness;
        colour[0] = req.colour_red;
        colour[1] = req.colour_green;
        colour[2] = req.colour_blue;
        for (int j = 0; j < LEDS; j++)
            for (int c = 0; c < 3; c++)
                ring[j][c] = 8'd0;
        for (int i = 0; i < POINTS; i++)
        begin
            blend = (64'd65536 - w) * shape_lut[req.model_source][i % 8]
                  + w * shape_lut[req.model_target][i % 8];
            pos = (blend * LEDS) >> 5;
            f = int'(pos >> 16);
            frac = pos & 64'hFFFF;
            taps = (frac != 0) ? 5 : 4;
            for (int t = 0; t < taps; t++)
            begin
                if (t == 0)
                    absd = frac + 64'd65536;
                else if (t == 1)
                    absd = frac;
                else
                    absd = 64'(t - 1) * 64'd65536 - frac;
                k = (absd + 64'd2048) >> 12;
                g = (k > 40) ? 9'd0 : gauss_lut[k];
                idx = (f + LEDS - 1 + t) % LEDS;
                for (int c = 0; c < 3; c++)
                begin
                    sum = 64'(ring[idx][c]) + ((64'(colour[c]) * g + 64'd128) >> 8);
                    ring[idx][c] = (sum > 255) ? 8'd255 : sum[7:0];
                end
            end
        end
        for (int j = 0; j < LEDS; j++)
        begin
            led.led_index  = 6'(j);
            led.out_red    = 8'((32'(ring[j][0]) * bright + 128) >> 8);
            led.out_green  = 8'((32'(ring[j][1]) * bright + 128) >> 8);
            led.out_blue   = 8'((32'(ring[j][2]) * bright + 128) >> 8);
            led.frame_last = (j == LEDS - 1);
            expected_leds.push_back(led);
        end
    endtask

    function automatic grps_pkg::in_item_t make_frame(input logic morph, input logic [1:0] src,
                                            input logic [1:0] tgt, input logic [15:0] wt,
                                            input logic [7:0] r, input logic [7:0] gr,
                                            input logic [7:0] b, input logic [8:0] br);
        grps_pkg::in_item_t it;
        it.morph_active = morph;
        it.model_source = src;
        it.model_target = tgt;
        it.blend_weight = wt;
        it.colour_red   = r;
        it.colour_green = gr;
        it.colour_blue  = b;
        it.brightness   = br;
        return it;
    endfunction

    function automatic grps_pkg::in_item_t random_frame();
        grps_pkg::in_item_t it;
        logic [8:0] br;
        it = $bits(grps_pkg::in_item_t)'({$urandom, $urandom});
        // mostly legal brightness, some above full scale
        case ($urandom_range(0, 9))
            0: br = 9'd256;
            1: br = 9'(256 + $urandom_range(1, 255));
            2: br = 9'd0;
            default: br = 9'($urandom_range(0, 256));
        endcase
        it.brightness = br;
        return it;
    endfunction

    // Sender: item changes only after acceptance, valid held while stalled.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_taken)
        begin
            if (pending_frames.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_frames.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            predict_frame(in_data);
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off  <= hold_off - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_leds.size() == 0)
            begin
                $error("unexpected LED result index %0d", out_data.led_index);
                fail_count++;
            end
            else
            begin
                grps_pkg::out_item_t exp_led;
                exp_led = expected_leds.pop_front();
                if (out_data.led_index !== exp_led.led_index)
                begin
                    $error("led_index expected %0d actual %0d",
                           exp_led.led_index, out_data.led_index);
                    fail_count++;
                end
                if (out_data.out_red !== exp_led.out_red)
                begin
                    $error("out_red expected %0d actual %0d", exp_led.out_red, out_data.out_red);
                    fail_count++;
                end
                if (out_data.out_green !== exp_led.out_green)
                begin
                    $error("out_green expected %0d actual %0d",
                           exp_led.out_green, out_data.out_green);
                    fail_count++;
                end
                if (out_data.out_blue !== exp_led.out_blue)
                begin
                    $error("out_blue expected %0d actual %0d",
                           exp_led.out_blue, out_data.out_blue);
                    fail_count++;
                end
                if (out_data.frame_last !== exp_led.frame_last)
                begin
                    $error("frame_last expected %0d actual %0d",
                           exp_led.frame_last, out_data.frame_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_frames.size() == 0);
        @(posedge clk);
        while (in_valid || expected_leds.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        fail_count    = 0;
        cycle_count   = 0;
        stim_done     = 0;
        hold_off      = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: each model alone, morph ends, wrap, saturation, brightness range
        for (int m = 0; m < 4; m++)
            pending_frames.push_back(make_frame(0, 2'(m), 2'(3 - m), 16'hFFFF,
                                                8'd255, 8'd128, 8'd1, 9'd256));
        pending_frames.push_back(make_frame(1, 0, 1, 16'h0000, 8'd200, 8'd100, 8'd50, 9'd256));
        pending_frames.push_back(make_frame(1, 0, 1, 16'hFFFF, 8'd200, 8'd100, 8'd50, 9'd256));
        pending_frames.push_back(make_frame(1, 2, 3, 16'h8000, 8'd255, 8'd255, 8'd255, 9'd255));
        pending_frames.push_back(make_frame(1, 3, 2, 16'h0001, 8'd255, 8'd255, 8'd255, 9'd128));
        pending_frames.push_back(make_frame(1, 1, 1, 16'h5555, 8'd0, 8'd0, 8'd0, 9'd256));
        pending_frames.push_back(make_frame(1, 1, 2, 16'hAAAA, 8'd17, 8'd240, 8'd99, 9'd0));
        pending_frames.push_back(make_frame(1, 2, 0, 16'h7FFF, 8'd255, 8'd0, 8'd255, 9'd511));
        pending_frames.push_back(make_frame(1, 3, 0, 16'hC000, 8'd1, 8'd2, 8'd3, 9'd257));
        pending_frames.push_back(make_frame(0, 3, 3, 16'h1234, 8'd170, 8'd85, 8'd255, 9'd1));
        drain();

        // receiver holds off long while the sender keeps offering
        hold_off = 400;
        for (int i = 0; i < 8; i++)
            pending_frames.push_back(random_frame());
        drain();

        send_idle_pct = 30;
        recv_idle_pct = 64;
        for (int i = 0; i < N_RANDOM / 3; i++)
            pending_frames.push_back(random_frame());
        drain();
        send_idle_pct = 64;
        recv_idle_pct = 30;
        for (int i = 0; i < N_RANDOM / 3; i++)
            pending_frames.push_back(random_frame());
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < N_RANDOM / 3; i++)
            pending_frames.push_back(random_frame());
        drain();
        repeat (200) @(posedge clk);

        if (fail_count == 0 && expected_leds.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/grps_pkg.sv
rtl/core/grps_front.sv
rtl/core/grps_back.sv
rtl/core/gaussian_ring_point_splat_unit.sv
test/tb.sv
